// ----- src/hybrid_shortest_remaining_scheduler_core_assert.svh -----
// Assertion macros used by the checker file of the scheduler core.
`ifndef HYBRID_SHORTEST_REMAINING_SCHEDULER_CORE_ASSERT_SVH
`define HYBRID_SHORTEST_REMAINING_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, checked only while reset is released.
`define HSRS_ASSERT_RST(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while reset is released.
`define HSRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hsrs_pkg.sv -----
package hsrs_pkg;

  localparam int unsigned QDepth = 16;
  localparam int unsigned IdxW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);
  localparam int unsigned CountW = 5;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [2:0] {
    REQ_ADD        = 3'd0,
    REQ_REM_ID     = 3'd1,
    REQ_REM_CLIENT = 3'd2,
    REQ_SELECT     = 3'd3,
    REQ_QUERY      = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CLIENT,
    S_SCAN,
    S_PICK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  task_id;
    logic [7:0]  client_id;
    logic [15:0] remaining_time;
    logic        is_shell;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_task_id;
    logic [7:0]  found_client_id;
    logic [15:0] found_remaining;
    logic        found_shell;
    logic        preempt;
    count_t      removed_count;
    count_t      queue_count;
  } out_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [7:0]  client_id;
    logic [15:0] remaining;
    logic        shell;
  } entry_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [7:0]  client_id;
    logic [15:0] remaining;
    logic [7:0]  last_id;
  } cell_key_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic id_eq;
    logic last_eq;
    logic client_eq;
    logic hot;
  } cell_flags_t;

  // Position of the lowest set bit, zero when none is set.
  function automatic idx_t first_idx(input logic [QDepth-1:0] vec);
    idx_t pos;
    pos = '0;
    for (int i = QDepth - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = idx_t'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ----- src/hsrs_cell.sv -----
module hsrs_cell (
  input  logic                 clk_i,
  input  hsrs_pkg::cell_ctrl_t ctrl_i,
  input  hsrs_pkg::entry_t     load_i,
  input  hsrs_pkg::entry_t     next_i,
  input  hsrs_pkg::cell_key_t  key_i,
  output hsrs_pkg::entry_t     entry_o,
  output hsrs_pkg::cell_flags_t flags_o
);

  hsrs_pkg::entry_t entry_q;

  // A cell either takes a new entry or the one from its right neighbor.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= load_i;
    end else if (ctrl_i.shift) begin
      entry_q <= next_i;
    end
  end

  always_comb begin
    flags_o.id_eq     = (entry_q.task_id == key_i.task_id);
    flags_o.last_eq   = (entry_q.task_id == key_i.last_id);
    flags_o.client_eq = (entry_q.client_id == key_i.client_id);
    flags_o.hot       = entry_q.shell ||
                        ((entry_q.remaining != '0) && (entry_q.remaining < key_i.remaining));
  end

  assign entry_o = entry_q;

endmodule

// ----- src/hybrid_shortest_remaining_scheduler_core.sv -----
// Shortest-remaining-time-first task queue with shell priority.
// Input channel: in_valid_i / in_stall_o carry one request transaction
// (add, remove by id, remove by client, select next, preempt query).
// Output channel: out_valid_o / out_stall_i carry exactly one result
// transaction for every request, in request order.
// The queue lives in a row of cells; a deletion makes every cell at or
// after the hole take its right neighbor's entry, so arrival order holds.
// Add, remove by id, preempt query and a select that finds a shell entry
// update the cells in EXEC, then load the output register in EMIT; the
// next request is taken in EMIT as the output register is loaded.
// Remove by client deletes one match per cycle until none is left.
// A select without a usable shell entry scans the cells one per cycle
// for the smallest remaining time.
// Reset empties the queue and forgets the last chosen id; no pass over the
// cells is needed. A stalled result is held in the output register; the
// core finishes the work of the next request and then waits until the
// output register is free before taking another one.
module hybrid_shortest_remaining_scheduler_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  hsrs_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output hsrs_pkg::out_t  out_data_o
);

  localparam int unsigned Depth = hsrs_pkg::QDepth;

  hsrs_pkg::state_e state_q, state_d;
  hsrs_pkg::cnt_t   count_q, count_d;
  hsrs_pkg::cnt_t   removed_q, removed_d;
  hsrs_pkg::idx_t   scan_q, scan_d;
  hsrs_pkg::idx_t   pick_q, pick_d;
  logic [15:0]      best_q, best_d;
  logic             have_q, have_d;
  logic             last_valid_q, last_valid_d;
  logic [7:0]       last_id_q, last_id_d;
  hsrs_pkg::in_t    req_q, req_d;
  hsrs_pkg::out_t   res_q, res_d;
  logic             out_valid_q;
  hsrs_pkg::out_t   out_q;
  hsrs_pkg::out_t   emit_res;

  hsrs_pkg::entry_t      cell_entry [Depth];
  hsrs_pkg::cell_flags_t cell_flags [Depth];
  hsrs_pkg::cell_ctrl_t  cell_ctrl  [Depth];
  hsrs_pkg::cell_key_t   key;
  hsrs_pkg::entry_t      new_entry;

  logic [Depth-1:0] occupied;
  logic [Depth-1:0] id_hit;
  logic [Depth-1:0] client_hit;
  logic [Depth-1:0] skip;
  logic [Depth-1:0] shell_hit;
  logic [Depth-1:0] hot_hit;

  logic             do_load;
  logic             do_drop;
  hsrs_pkg::idx_t   drop_pos;
  hsrs_pkg::idx_t   rd_idx;
  hsrs_pkg::entry_t rd_entry;
  logic             slot_free;
  logic             take_req;
  logic             out_load;

  assign key.task_id   = req_q.task_id;
  assign key.client_id = req_q.client_id;
  assign key.remaining = req_q.remaining_time;
  assign key.last_id   = last_id_q;

  assign new_entry.task_id   = req_q.task_id;
  assign new_entry.client_id = req_q.client_id;
  assign new_entry.remaining = req_q.remaining_time;
  assign new_entry.shell     = req_q.is_shell;

  // The row of cells. The last cell has no right neighbor and keeps its own
  // entry when shifted; that slot falls outside the queue after a deletion.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i < Depth - 1) begin : g_mid
      hsrs_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (cell_ctrl[i]),
        .load_i  (new_entry),
        .next_i  (cell_entry[i+1]),
        .key_i   (key),
        .entry_o (cell_entry[i]),
        .flags_o (cell_flags[i])
      );
    end else begin : g_last
      hsrs_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (cell_ctrl[i]),
        .load_i  (new_entry),
        .next_i  (cell_entry[i]),
        .key_i   (key),
        .entry_o (cell_entry[i]),
        .flags_o (cell_flags[i])
      );
    end

    // Only cells below the count belong to the queue.
    assign occupied[i]   = (hsrs_pkg::cnt_t'(i) < count_q);
    assign id_hit[i]     = occupied[i] && cell_flags[i].id_eq;
    assign client_hit[i] = occupied[i] && cell_flags[i].client_eq;
    // The last chosen id is passed over while more than one entry waits.
    assign skip[i]       = last_valid_q && cell_flags[i].last_eq &&
                           (count_q > hsrs_pkg::cnt_t'(1));
    assign shell_hit[i]  = occupied[i] && cell_entry[i].shell && !skip[i];
    assign hot_hit[i]    = occupied[i] && cell_flags[i].hot;

    assign cell_ctrl[i].load  = do_load && (hsrs_pkg::cnt_t'(i) == count_q);
    assign cell_ctrl[i].shift = do_drop && (hsrs_pkg::idx_t'(i) >= drop_pos);
  end

  assign rd_entry = cell_entry[rd_idx];

  // The output register is free when empty or being taken this cycle.
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign take_req   = (state_q == hsrs_pkg::S_IDLE) ||
                      ((state_q == hsrs_pkg::S_EMIT) && slot_free);
  assign in_stall_o = !take_req;

  // The queue count is taken once the request's work on the cells is done.
  always_comb begin
    emit_res             = res_q;
    emit_res.queue_count = hsrs_pkg::count_t'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hsrs_pkg::S_IDLE;
      count_q      <= '0;
      removed_q    <= '0;
      scan_q       <= '0;
      have_q       <= 1'b0;
      last_valid_q <= 1'b0;
      last_id_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      removed_q    <= removed_d;
      scan_q       <= scan_d;
      have_q       <= have_d;
      last_valid_q <= last_valid_d;
      last_id_q    <= last_id_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    best_q <= best_d;
    pick_q <= pick_d;
    if (out_load) begin
      out_q <= emit_res;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    removed_d    = removed_q;
    scan_d       = scan_q;
    pick_d       = pick_q;
    best_d       = best_q;
    have_d       = have_q;
    last_valid_d = last_valid_q;
    last_id_d    = last_id_q;
    req_d        = req_q;
    res_d        = res_q;
    do_load      = 1'b0;
    do_drop      = 1'b0;
    drop_pos     = '0;
    rd_idx       = '0;
    out_load     = 1'b0;

    case (state_q)
      hsrs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = hsrs_pkg::S_EXEC;
        end
      end

      hsrs_pkg::S_EXEC: begin
        res_d        = '0;
        res_d.status = hsrs_pkg::ST_OK;
        state_d      = hsrs_pkg::S_EMIT;
        case (req_q.req_type)
          hsrs_pkg::REQ_ADD: begin
            if (count_q == hsrs_pkg::cnt_t'(Depth)) begin
              res_d.status = hsrs_pkg::ST_FULL;
            end else begin
              do_load = 1'b1;
              count_d = count_q + hsrs_pkg::cnt_t'(1);
            end
          end
          hsrs_pkg::REQ_REM_ID: begin
            if (|id_hit) begin
              drop_pos              = hsrs_pkg::first_idx(id_hit);
              rd_idx                = drop_pos;
              do_drop               = 1'b1;
              count_d               = count_q - hsrs_pkg::cnt_t'(1);
              res_d.found_task_id   = rd_entry.task_id;
              res_d.found_client_id = rd_entry.client_id;
              res_d.found_remaining = rd_entry.remaining;
              res_d.found_shell     = rd_entry.shell;
              res_d.removed_count   = hsrs_pkg::count_t'(1);
            end else begin
              res_d.status = hsrs_pkg::ST_NONE;
            end
          end
          hsrs_pkg::REQ_REM_CLIENT: begin
            removed_d = '0;
            state_d   = hsrs_pkg::S_CLIENT;
          end
          hsrs_pkg::REQ_SELECT: begin
            if (count_q == '0) begin
              res_d.status = hsrs_pkg::ST_NONE;
            end else if (|shell_hit) begin
              drop_pos              = hsrs_pkg::first_idx(shell_hit);
              rd_idx                = drop_pos;
              do_drop               = 1'b1;
              count_d               = count_q - hsrs_pkg::cnt_t'(1);
              res_d.found_task_id   = rd_entry.task_id;
              res_d.found_client_id = rd_entry.client_id;
              res_d.found_remaining = rd_entry.remaining;
              res_d.found_shell     = rd_entry.shell;
              res_d.removed_count   = hsrs_pkg::count_t'(1);
              last_valid_d          = 1'b1;
              last_id_d             = rd_entry.task_id;
            end else begin
              scan_d  = '0;
              have_d  = 1'b0;
              state_d = hsrs_pkg::S_SCAN;
            end
          end
          hsrs_pkg::REQ_QUERY: begin
            res_d.preempt = |hot_hit;
          end
          default: begin
            // Unused request kinds leave the queue alone and report ok.
          end
        endcase
      end

      hsrs_pkg::S_CLIENT: begin
        // One matching entry leaves per cycle until none is left.
        if (|client_hit) begin
          drop_pos  = hsrs_pkg::first_idx(client_hit);
          do_drop   = 1'b1;
          count_d   = count_q - hsrs_pkg::cnt_t'(1);
          removed_d = removed_q + hsrs_pkg::cnt_t'(1);
        end else begin
          res_d.status        = (removed_q != '0) ? hsrs_pkg::ST_OK : hsrs_pkg::ST_NONE;
          res_d.removed_count = hsrs_pkg::count_t'(removed_q);
          state_d             = hsrs_pkg::S_EMIT;
        end
      end

      hsrs_pkg::S_SCAN: begin
        // Strict less-than keeps the earliest entry on a tie.
        rd_idx = scan_q;
        if (!skip[scan_q] && (!have_q || (rd_entry.remaining < best_q))) begin
          have_d = 1'b1;
          best_d = rd_entry.remaining;
          pick_d = scan_q;
        end
        scan_d = scan_q + hsrs_pkg::idx_t'(1);
        if (scan_q == hsrs_pkg::idx_t'(count_q - hsrs_pkg::cnt_t'(1))) begin
          state_d = hsrs_pkg::S_PICK;
        end
      end

      hsrs_pkg::S_PICK: begin
        // With every entry skipped, the head of the queue is taken.
        drop_pos              = have_q ? pick_q : '0;
        rd_idx                = drop_pos;
        do_drop               = 1'b1;
        count_d               = count_q - hsrs_pkg::cnt_t'(1);
        res_d.found_task_id   = rd_entry.task_id;
        res_d.found_client_id = rd_entry.client_id;
        res_d.found_remaining = rd_entry.remaining;
        res_d.found_shell     = rd_entry.shell;
        res_d.removed_count   = hsrs_pkg::count_t'(1);
        last_valid_d          = 1'b1;
        last_id_d             = rd_entry.task_id;
        state_d               = hsrs_pkg::S_EMIT;
      end

      hsrs_pkg::S_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (in_valid_i) begin
            req_d   = in_data_i;
            state_d = hsrs_pkg::S_EXEC;
          end else begin
            state_d = hsrs_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_d = hsrs_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/hsrs_checker.sv -----
`include "hybrid_shortest_remaining_scheduler_core_assert.svh"

module hsrs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input hsrs_pkg::out_t out_data_o
);

  `HSRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `HSRS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o), "result changed while stalled")
  `HSRS_ASSERT_RST(a_full_count, clk_i, rst_ni, out_valid_o && (out_data_o.status == hsrs_pkg::ST_FULL), out_data_o.queue_count == hsrs_pkg::count_t'(hsrs_pkg::QDepth), "full reported on a queue with room")
  `HSRS_ASSERT_RST(a_none_removed, clk_i, rst_ni, out_valid_o && (out_data_o.status == hsrs_pkg::ST_NONE), out_data_o.removed_count == '0, "entries removed on a not-found result")
  `HSRS_ASSERT_RST(a_count_bound, clk_i, rst_ni, out_valid_o, out_data_o.queue_count <= hsrs_pkg::count_t'(hsrs_pkg::QDepth), "queue count beyond depth")

endmodule

bind hybrid_shortest_remaining_scheduler_core hsrs_checker u_hsrs_checker (.*);
